FILE: sv/psd3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd3_pkg
// Types and constants shared by the point to segment distance core.
// ----------------------------------------------------------------------------
package psd3_pkg;

   localparam int COORD_BITS  = 16;
   localparam int THR_BITS    = 16;
   localparam int DIST_BITS   = 25;
   localparam int FEAT_BITS   = 2;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int DOT_BITS    = PROD_BITS + 2;
   localparam int CROSS_BITS  = PROD_BITS + 1;
   localparam int MAG_BITS    = PROD_BITS;
   localparam int SQ_BITS     = 2 * MAG_BITS;
   localparam int SUMSQ_BITS  = SQ_BITS + 2;
   localparam int NUM_BITS    = SUMSQ_BITS + 16;
   localparam int DEN_BITS    = PROD_BITS;
   localparam int RD_BITS     = DEN_BITS + DIST_BITS;
   localparam int ACC_BITS    = NUM_BITS + 2;

   localparam logic [FEAT_BITS-1:0] FEAT_START    = 2'd0;
   localparam logic [FEAT_BITS-1:0] FEAT_END      = 2'd1;
   localparam logic [FEAT_BITS-1:0] FEAT_INTERIOR = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] start_z;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic signed [COORD_BITS-1:0] end_z;
      logic signed [COORD_BITS-1:0] query_x;
      logic signed [COORD_BITS-1:0] query_y;
      logic signed [COORD_BITS-1:0] query_z;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] dist_res;
      logic [FEAT_BITS-1:0] nearest_feature;
   } rsp_type;

endpackage

FILE: sv/point_segment_distance_3d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_3d_core
// Distance from a point to a 3D segment, Q8.8 inputs, 16 fractional bits out.
//
//   channel   ports                         flow control
//   request   start, busy, req_data         accepted when start and not busy
//   response  rsp_valid, rsp_data           one-cycle strobe, no backpressure
//   csr       csr_valid, csr_ready, csr_wdata  written when valid and ready
//
// One item enters every cycle; busy is always low.
// Each result passes five arithmetic stages and a 25-stage square root
// search, one result bit a stage, and is registered before it leaves.
// Reset clears the valid bits and sets the threshold register thr_ff to 1.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_core
   import psd3_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [THR_BITS-1:0] csr_wdata
);

   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [DOT_BITS-1:0]   dot_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;

   logic [THR_BITS-1:0] thr_ff;

   // Stage 1: differences.
   logic     s1_valid_ff;
   diff_type e_ff [3];
   diff_type f_ff [3];
   diff_type ne_ff [3];
   diff_type g_ff [3];
   diff_type e_in [3];
   diff_type f_in [3];
   diff_type ne_in [3];
   diff_type g_in [3];

   // Stage 2: products.
   logic     s2_valid_ff;
   prod_type pef_ff [3];
   prod_type png_ff [3];
   prod_type pee_ff [3];
   prod_type pff_ff [3];
   prod_type pgg_ff [3];
   prod_type pcx_ff [6];

   // Stage 3: sums.
   logic      s3_valid_ff;
   dot_type   def_ff;
   dot_type   dng_ff;
   dot_type   dee_ff;
   dot_type   dff_ff;
   dot_type   dgg_ff;
   cross_type c_ff [3];

   // Stage 4: squares of the cross product and the feature decision.
   logic                 s4_valid_ff;
   logic [SQ_BITS-1:0]   csq_ff [3];
   logic [DEN_BITS-1:0]  e2_ff;
   logic [DEN_BITS-1:0]  ff2_ff;
   logic [DEN_BITS-1:0]  gg2_ff;
   logic [FEAT_BITS-1:0] s4_feat_ff;
   logic [FEAT_BITS-1:0] feat_in;
   logic [MAG_BITS-1:0]  cmag [3];
   logic signed [DOT_BITS-1:0] thr_ext;
   logic                 e2_zero;

   // Square root search stages; index 0 is loaded by stage 5.
   logic                 rv_ff   [DIST_BITS+1];
   logic [NUM_BITS-1:0]  num_ff  [DIST_BITS+1];
   logic [DEN_BITS-1:0]  den_ff  [DIST_BITS+1];
   logic [ACC_BITS-1:0]  r2d_ff  [DIST_BITS+1];
   logic [RD_BITS-1:0]   rd_ff   [DIST_BITS+1];
   logic [DIST_BITS-1:0] r_ff    [DIST_BITS+1];
   logic [FEAT_BITS-1:0] rfeat_ff [DIST_BITS+1];
   logic [SUMSQ_BITS-1:0] c2_sum;
   logic [NUM_BITS-1:0]  num_in;
   logic [DEN_BITS-1:0]  den_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_wdata;
      end
   end

   always_comb begin
      e_in[0]  = DIFF_BITS'(req_data.end_x) - DIFF_BITS'(req_data.start_x);
      e_in[1]  = DIFF_BITS'(req_data.end_y) - DIFF_BITS'(req_data.start_y);
      e_in[2]  = DIFF_BITS'(req_data.end_z) - DIFF_BITS'(req_data.start_z);
      f_in[0]  = DIFF_BITS'(req_data.query_x) - DIFF_BITS'(req_data.start_x);
      f_in[1]  = DIFF_BITS'(req_data.query_y) - DIFF_BITS'(req_data.start_y);
      f_in[2]  = DIFF_BITS'(req_data.query_z) - DIFF_BITS'(req_data.start_z);
      ne_in[0] = DIFF_BITS'(req_data.start_x) - DIFF_BITS'(req_data.end_x);
      ne_in[1] = DIFF_BITS'(req_data.start_y) - DIFF_BITS'(req_data.end_y);
      ne_in[2] = DIFF_BITS'(req_data.start_z) - DIFF_BITS'(req_data.end_z);
      g_in[0]  = DIFF_BITS'(req_data.query_x) - DIFF_BITS'(req_data.end_x);
      g_in[1]  = DIFF_BITS'(req_data.query_y) - DIFF_BITS'(req_data.end_y);
      g_in[2]  = DIFF_BITS'(req_data.query_z) - DIFF_BITS'(req_data.end_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         rv_ff[0]    <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         rv_ff[0]    <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e_ff[i]  <= e_in[i];
         f_ff[i]  <= f_in[i];
         ne_ff[i] <= ne_in[i];
         g_ff[i]  <= g_in[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pef_ff[i] <= e_ff[i] * f_ff[i];
         png_ff[i] <= ne_ff[i] * g_ff[i];
         pee_ff[i] <= e_ff[i] * e_ff[i];
         pff_ff[i] <= f_ff[i] * f_ff[i];
         pgg_ff[i] <= g_ff[i] * g_ff[i];
      end
      pcx_ff[0] <= e_ff[1] * f_ff[2];
      pcx_ff[1] <= e_ff[2] * f_ff[1];
      pcx_ff[2] <= e_ff[2] * f_ff[0];
      pcx_ff[3] <= e_ff[0] * f_ff[2];
      pcx_ff[4] <= e_ff[0] * f_ff[1];
      pcx_ff[5] <= e_ff[1] * f_ff[0];
   end

   always_ff @(posedge clock) begin
      def_ff <= DOT_BITS'(pef_ff[0]) + DOT_BITS'(pef_ff[1]) + DOT_BITS'(pef_ff[2]);
      dng_ff <= DOT_BITS'(png_ff[0]) + DOT_BITS'(png_ff[1]) + DOT_BITS'(png_ff[2]);
      dee_ff <= DOT_BITS'(pee_ff[0]) + DOT_BITS'(pee_ff[1]) + DOT_BITS'(pee_ff[2]);
      dff_ff <= DOT_BITS'(pff_ff[0]) + DOT_BITS'(pff_ff[1]) + DOT_BITS'(pff_ff[2]);
      dgg_ff <= DOT_BITS'(pgg_ff[0]) + DOT_BITS'(pgg_ff[1]) + DOT_BITS'(pgg_ff[2]);
      c_ff[0] <= CROSS_BITS'(pcx_ff[0]) - CROSS_BITS'(pcx_ff[1]);
      c_ff[1] <= CROSS_BITS'(pcx_ff[2]) - CROSS_BITS'(pcx_ff[3]);
      c_ff[2] <= CROSS_BITS'(pcx_ff[4]) - CROSS_BITS'(pcx_ff[5]);
   end

   always_comb begin
      thr_ext = $signed({{(DOT_BITS-THR_BITS){1'b0}}, thr_ff});
      e2_zero = (dee_ff == '0);
      for (int i = 0; i < 3; i++) begin
         cmag[i] = c_ff[i][CROSS_BITS-1] ? MAG_BITS'(-c_ff[i]) : MAG_BITS'(c_ff[i]);
      end
      if ((def_ff < thr_ext) || ((dng_ff >= thr_ext) && e2_zero)) begin
         feat_in = FEAT_START;
      end else if (dng_ff < thr_ext) begin
         feat_in = FEAT_END;
      end else begin
         feat_in = FEAT_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         csq_ff[i] <= cmag[i] * cmag[i];
      end
      e2_ff      <= dee_ff[DEN_BITS-1:0];
      ff2_ff     <= dff_ff[DEN_BITS-1:0];
      gg2_ff     <= dgg_ff[DEN_BITS-1:0];
      s4_feat_ff <= feat_in;
   end

   always_comb begin
      c2_sum = SUMSQ_BITS'(csq_ff[0]) + SUMSQ_BITS'(csq_ff[1]) + SUMSQ_BITS'(csq_ff[2]);
      case (s4_feat_ff)
         FEAT_START: begin
            num_in = NUM_BITS'({ff2_ff, 16'd0});
            den_in = DEN_BITS'(1);
         end
         FEAT_END: begin
            num_in = NUM_BITS'({gg2_ff, 16'd0});
            den_in = DEN_BITS'(1);
         end
         default: begin
            num_in = {c2_sum, 16'd0};
            den_in = e2_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff[0]   <= num_in;
      den_ff[0]   <= den_in;
      r2d_ff[0]   <= '0;
      rd_ff[0]    <= '0;
      r_ff[0]     <= '0;
      rfeat_ff[0] <= s4_feat_ff;
   end

   // Each stage tries one result bit: (r + 2^b)^2 * den is built from the
   // running r^2 * den and r * den, so only shifts and adds are needed.
   for (genvar k = 0; k < DIST_BITS; k++) begin : g_root
      localparam int B = DIST_BITS - 1 - k;
      logic [ACC_BITS-1:0] trial;
      logic                take;

      assign trial = r2d_ff[k] + (ACC_BITS'(rd_ff[k]) << (B + 1))
                   + (ACC_BITS'(den_ff[k]) << (2 * B));
      assign take  = (trial <= ACC_BITS'(num_ff[k]));

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[k+1] <= 1'b0;
         end else begin
            rv_ff[k+1] <= rv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         num_ff[k+1]   <= num_ff[k];
         den_ff[k+1]   <= den_ff[k];
         rfeat_ff[k+1] <= rfeat_ff[k];
         if (take) begin
            r2d_ff[k+1] <= trial;
            rd_ff[k+1]  <= rd_ff[k] + (RD_BITS'(den_ff[k]) << B);
            r_ff[k+1]   <= r_ff[k] | (DIST_BITS'(1) << B);
         end else begin
            r2d_ff[k+1] <= r2d_ff[k];
            rd_ff[k+1]  <= rd_ff[k];
            r_ff[k+1]   <= r_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= rv_ff[DIST_BITS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data.dist_res        <= r_ff[DIST_BITS];
      rsp_data.nearest_feature <= rfeat_ff[DIST_BITS];
   end

endmodule

FILE: tb/point_segment_distance_3d_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_3d_core_tb
// Self-checking bench for the point to segment distance core.
//
// A short table of directed items runs first. Some rows carry hand-worked
// results and the rest go to the distance predictor. After that, random
// segments and points run under several threshold settings, zero and the
// maximum among them. Every strobed result is checked field by field against
// the oldest queued expectation.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_core_tb;
   import psd3_pkg::*;

   localparam int LATENCY    = 31;
   localparam int DRAIN_WAIT = LATENCY + 10;
   localparam int STALL_MAX  = 4000;

   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } vector_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [THR_BITS-1:0] csr_wdata;

   rsp_type             expected_q[$];
   vector_type          vectors[$];
   logic [THR_BITS-1:0] threshold;
   int                  errors;
   int                  stall_count;
   bit                  no_idle;

   point_segment_distance_3d_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [DIST_BITS-1:0] root_of_ratio(logic [127:0] num,
                                                          logic [127:0] den);
      logic [127:0] r;
      logic [127:0] c;
      r = '0;
      for (int b = DIST_BITS - 1; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c * den <= num) begin
            r = c;
         end
      end
      return r[DIST_BITS-1:0];
   endfunction

   function automatic logic [127:0] square_mag(longint v);
      logic [127:0] m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      return m * m;
   endfunction

   function automatic rsp_type predict_distance(req_type r, logic [THR_BITS-1:0] thr);
      longint       a[3];
      longint       b[3];
      longint       p[3];
      longint       e[3];
      longint       f[3];
      longint       g[3];
      longint       c[3];
      longint       dot_a;
      longint       dot_b;
      longint       len2;
      longint       lim;
      logic [127:0] sum;
      rsp_type      res;
      a = '{r.start_x, r.start_y, r.start_z};
      b = '{r.end_x, r.end_y, r.end_z};
      p = '{r.query_x, r.query_y, r.query_z};
      for (int i = 0; i < 3; i++) begin
         e[i] = b[i] - a[i];
         f[i] = p[i] - a[i];
         g[i] = p[i] - b[i];
      end
      lim   = longint'(thr);
      dot_a = e[0] * f[0] + e[1] * f[1] + e[2] * f[2];
      dot_b = -(e[0] * g[0] + e[1] * g[1] + e[2] * g[2]);
      len2  = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
      if (dot_a < lim || len2 == 0) begin
         sum = square_mag(f[0]) + square_mag(f[1]) + square_mag(f[2]);
         res.dist_res        = root_of_ratio(sum << 16, 128'd1);
         res.nearest_feature = FEAT_START;
      end else if (dot_b < lim) begin
         sum = square_mag(g[0]) + square_mag(g[1]) + square_mag(g[2]);
         res.dist_res        = root_of_ratio(sum << 16, 128'd1);
         res.nearest_feature = FEAT_END;
      end else begin
         c[0] = e[1] * f[2] - e[2] * f[1];
         c[1] = e[2] * f[0] - e[0] * f[2];
         c[2] = e[0] * f[1] - e[1] * f[0];
         sum = square_mag(c[0]) + square_mag(c[1]) + square_mag(c[2]);
         res.dist_res        = root_of_ratio(sum << 16, 128'(len2));
         res.nearest_feature = FEAT_INTERIOR;
      end
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if (start && !busy) begin
            if (vectors.size() > 0 && vectors[0].req == req_data) begin
               if (vectors[0].known) begin
                  expected_q.push_back(vectors[0].rsp);
               end else begin
                  expected_q.push_back(predict_distance(req_data, threshold));
               end
               void'(vectors.pop_front());
            end else begin
               expected_q.push_back(predict_distance(req_data, threshold));
            end
         end
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result strobed with no item outstanding");
            end else begin
               exp_rsp = expected_q.pop_front();
               if (rsp_data.dist_res !== exp_rsp.dist_res) begin
                  report_mismatch($sformatf("dist_res %0d, expected %0d",
                                            rsp_data.dist_res, exp_rsp.dist_res));
               end
               if (rsp_data.nearest_feature !== exp_rsp.nearest_feature) begin
                  report_mismatch($sformatf("nearest_feature %0d, expected %0d",
                                            rsp_data.nearest_feature,
                                            exp_rsp.nearest_feature));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_MAX) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic req_type make_req(int ax, int ay, int az, int bx, int by,
                                        int bz, int px, int py, int pz);
      req_type r;
      r.start_x = COORD_BITS'(ax);
      r.start_y = COORD_BITS'(ay);
      r.start_z = COORD_BITS'(az);
      r.end_x   = COORD_BITS'(bx);
      r.end_y   = COORD_BITS'(by);
      r.end_z   = COORD_BITS'(bz);
      r.query_x = COORD_BITS'(px);
      r.query_y = COORD_BITS'(py);
      r.query_z = COORD_BITS'(pz);
      return r;
   endfunction

   function automatic void add_row(req_type r, bit known, int dist_val, int feat);
      vector_type v;
      v.req                 = r;
      v.known               = known;
      v.rsp.dist_res        = DIST_BITS'(dist_val);
      v.rsp.nearest_feature = FEAT_BITS'(feat);
      vectors.push_back(v);
   endfunction

   function automatic int rand_coord(int mode);
      case (mode)
         0: begin
            return $urandom_range(0, 65535) - 32768;
         end
         1: begin
            return $urandom_range(0, 2000) - 1000;
         end
         2: begin
            return $urandom_range(0, 1) ? 32767 : -32768;
         end
         default: begin
            return $urandom_range(0, 16) - 8;
         end
      endcase
   endfunction

   function automatic req_type random_req();
      int      mode;
      int      kind;
      int      v[9];
      req_type r;
      mode = $urandom_range(0, 3);
      kind = $urandom_range(0, 9);
      foreach (v[i]) begin
         v[i] = rand_coord((kind == 9) ? $urandom_range(0, 3) : mode);
      end
      if (kind == 0) begin
         v[3] = v[0];
         v[4] = v[1];
         v[5] = v[2];
      end else if (kind == 1) begin
         v[6] = v[0] + $urandom_range(0, 4) - 2;
         v[7] = v[1];
         v[8] = v[2];
      end
      r = make_req(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
      return r;
   endfunction

   task automatic send_item(req_type r);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 29) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= r;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   task automatic write_threshold(logic [THR_BITS-1:0] value);
      start <= 1'b0;
      while (expected_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      while (!no_idle && $urandom_range(0, 99) < 29) begin
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      threshold = value;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [THR_BITS-1:0] settings[5];
      vector_type          rows[$];
      errors      = 0;
      stall_count = 0;
      threshold   = 16'd1;
      no_idle     = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;

      add_row(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, int'(FEAT_START));
      add_row(make_req(-32768, -32768, -32768, -32768, -32768, -32768,
                       -32768, -32768, -32768), 1, 0, int'(FEAT_START));
      add_row(make_req(0, 0, 0, 0, 0, 0, 256, 0, 0), 1, 65536, int'(FEAT_START));
      add_row(make_req(0, 0, 0, 512, 0, 0, 256, 256, 0), 1, 65536,
              int'(FEAT_INTERIOR));
      add_row(make_req(0, 0, 0, 256, 0, 0, 512, 0, 0), 1, 65536, int'(FEAT_END));
      add_row(make_req(0, 0, 0, 256, 0, 0, -256, 0, 0), 1, 65536, int'(FEAT_START));
      add_row(make_req(-32768, -32768, -32768, -32768, -32768, -32768,
                       32767, 32767, 32767), 0, 0, 0);
      add_row(make_req(32767, 32767, 32767, -32768, -32768, -32768,
                       0, 0, 0), 0, 0, 0);
      add_row(make_req(-32768, 32767, -32768, 32767, -32768, 32767,
                       32767, 32767, -32768), 0, 0, 0);
      add_row(make_req(-32768, 0, 0, 32767, 0, 0, 0, 32767, 32767), 0, 0, 0);
      add_row(make_req(0, 0, 0, 1, 0, 0, 0, 1, 0), 0, 0, 0);
      add_row(make_req(0, 0, 0, 1, 0, 0, 1, 0, 0), 0, 0, 0);
      add_row(make_req(5, -7, 9, 5, -7, 9, 5, -7, 9), 0, 0, 0);
      add_row(make_req(100, 200, -300, -400, 500, 600, 700, -800, 900), 0, 0, 0);
      add_row(make_req(1, 1, 1, 2, 2, 2, 1, 2, 1), 0, 0, 0);
      add_row(make_req(-1, -1, -1, 1, 1, 1, 0, 0, 0), 0, 0, 0);
      rows = vectors;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_item(rows[i].req);
      end

      settings = '{16'd0, 16'hFFFF, 16'($urandom_range(2, 65534)), 16'd300, 16'd1};
      for (int s = 0; s < 5; s++) begin
         write_threshold(settings[s]);
         no_idle = (s == 2);
         repeat (290) send_item(random_req());
      end
      start <= 1'b0;

      while (expected_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/psd3_pkg.sv
sv/point_segment_distance_3d_core.sv
tb/point_segment_distance_3d_core_tb.sv
